### design/lrupr_pkg.sv
// Shared constants and controller/datapath interface types for the LRU page replacement unit.
package lrupr_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int PAGE_ID_W   = 16;
    localparam int CAP_W       = 5;
    localparam int COUNT_W     = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Result fields: hit, evicted_valid, evicted_page, hit_count, access_count.
    localparam int RES_W  = 1 + 1 + PAGE_ID_W + COUNT_W + COUNT_W;
    localparam int TOUT_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic load;
        logic lookup;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

### design/lrupr_ctrl.sv
// Sequencer that steps each page reference through load, lookup and update.
module lrupr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  lrupr_pkg::t_dp_status i_status,
    output lrupr_pkg::t_dp_cmd    o_cmd
);
    import lrupr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_update_go;
    logic       w_accept;

    assign w_update_go = (r_state == S_UPDATE) && !i_status.out_busy;
    assign o_s_tready  = (r_state == S_IDLE) || w_update_go;
    assign w_accept    = i_s_tvalid && o_s_tready;

    assign o_cmd.load   = w_accept;
    assign o_cmd.lookup = (r_state == S_LOOKUP);
    assign o_cmd.update = w_update_go;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (w_update_go) n_state = w_accept ? S_LOOKUP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/lrupr_dp.sv
// Frame store, parallel page compare, recency shifting, counters and result register.
module lrupr_dp #(
    parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lrupr_pkg::t_dp_cmd                i_cmd,
    output lrupr_pkg::t_dp_status             o_status,
    input  logic [lrupr_pkg::PAGE_ID_W-1:0]   i_page_id,
    input  logic                              i_cfg_wr,
    input  logic [lrupr_pkg::CAP_W-1:0]       i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lrupr_pkg::TOUT_W-1:0]      o_out_data
);
    import lrupr_pkg::*;

    localparam int OCC_W = $clog2(MAX_FRAMES + 1);
    localparam int CW_W  = OCC_W + CAP_W;

    logic [PAGE_BITS-1:0] r_frame [MAX_FRAMES];
    logic [PAGE_BITS-1:0] r_page;
    logic [OCC_W-1:0]     r_occ;
    logic [OCC_W-1:0]     r_cap;
    logic [MAX_FRAMES-1:0] r_ge;
    logic                  r_hit;
    logic [COUNT_W-1:0]    r_hits;
    logic [COUNT_W-1:0]    r_acc;
    logic                  r_out_valid;
    logic                  r_res_hit;
    logic                  r_res_ev;
    logic [PAGE_ID_W-1:0]  r_res_evpage;

    logic [MAX_FRAMES-1:0] w_match;
    logic [MAX_FRAMES-1:0] n_ge;
    logic                  w_evict;
    logic [PAGE_BITS+PAGE_ID_W-1:0] w_in_ext;
    logic [PAGE_BITS+PAGE_ID_W-1:0] w_ev_ext;
    logic [CW_W-1:0]       w_cfg_wide;
    logic [CW_W-1:0]       w_rst_wide;

    // Effective capacity: zero acts as one, values above the store size clip to it.
    function automatic logic [OCC_W-1:0] f_eff_cap(input logic [CW_W-1:0] c);
        logic [CW_W-1:0] v;
        v = (c == '0) ? CW_W'(1) : c;
        if (v > CW_W'(MAX_FRAMES)) v = CW_W'(MAX_FRAMES);
        return v[OCC_W-1:0];
    endfunction

    assign w_cfg_wide = {{OCC_W{1'b0}}, i_cfg_data};
    assign w_rst_wide = {{OCC_W{1'b0}}, CAP_RESET};
    assign w_in_ext   = {{PAGE_BITS{1'b0}}, i_page_id};
    assign w_ev_ext   = {{PAGE_ID_W{1'b0}}, r_frame[0]};

    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            w_match[i] = (OCC_W'(i) < r_occ) && (r_frame[i] == r_page);
        end
        // Entries at or above the hit position shift down by one.
        n_ge[0] = w_match[0];
        for (int i = 1; i < MAX_FRAMES; i++) begin
            n_ge[i] = n_ge[i-1] | w_match[i];
        end
    end

    assign w_evict = !r_hit && (r_occ >= r_cap);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_page <= w_in_ext[PAGE_BITS-1:0];
        if (i_cmd.lookup) begin
            r_ge  <= n_ge;
            r_hit <= n_ge[MAX_FRAMES-1];
        end
        if (i_cmd.update) begin
            r_res_hit    <= r_hit;
            r_res_ev     <= w_evict;
            r_res_evpage <= w_evict ? w_ev_ext[PAGE_ID_W-1:0] : '0;
        end
    end

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_frame
        logic [PAGE_BITS-1:0] w_next_src;
        logic                 w_shift;
        logic                 w_last;
        logic                 w_app;

        if (g < MAX_FRAMES - 1) begin : g_src
            assign w_next_src = r_frame[g+1];
        end else begin : g_src_end
            assign w_next_src = r_frame[g];
        end

        assign w_shift = (r_hit ? r_ge[g] : w_evict) && (OCC_W'(g + 1) < r_occ);
        assign w_last  = (r_hit || w_evict) && (OCC_W'(g + 1) == r_occ);
        assign w_app   = !r_hit && !w_evict && (OCC_W'(g) == r_occ);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_frame[g] <= '0;
            end else if (i_cmd.update) begin
                if (w_shift) begin
                    r_frame[g] <= w_next_src;
                end else if (w_last || w_app) begin
                    r_frame[g] <= r_page;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_cap       <= f_eff_cap(w_rst_wide);
            r_hits      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) r_cap <= f_eff_cap(w_cfg_wide);
            if (i_cmd.update) begin
                if (!r_hit && !w_evict) r_occ <= r_occ + OCC_W'(1);
                if (r_hit && (r_hits != '1)) r_hits <= r_hits + COUNT_W'(1);
                if (r_acc != '1) r_acc <= r_acc + COUNT_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Counters only move on an update, which waits for the previous result to leave.
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data = TOUT_W'({r_acc, r_hits, r_res_evpage, r_res_ev, r_res_hit});

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(MAX_FRAMES))
        else $error("occupancy beyond frame store");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |-> $onehot0(w_match))
        else $error("page resident in more than one frame");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && r_out_valid |-> i_out_ready)
        else $error("pending result overwritten");

    a_fill_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && !r_hit && (r_occ < r_cap) |=> r_occ <= r_cap)
        else $error("append beyond capacity");

endmodule

### design/lru_page_replacement_unit.sv
// Top level of the LRU page replacement unit.
// Each page reference on the slave stream is looked up against all resident frames in
// parallel and answered by one result transaction: hit flag, eviction flag, evicted page
// and saturating hit and access counts. Each reference passes through the sequencer's
// lookup and update states; a new reference is taken in the update cycle of the previous
// one, and a result not yet taken holds the update of the next reference. Capacity
// writes on the configuration channel are always accepted and apply from the next update
// on, also to a reference already taken; zero acts as one and values above MAX_FRAMES
// act as MAX_FRAMES. Reset empties the frame store.
module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [lrupr_pkg::PAGE_ID_W-1:0]  i_s_tdata,   // [15:0] page_id
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] hit, [1] evicted_valid, [17:2] evicted_page, [49:18] hit_count,
    // [81:50] access_count, [87:82] zero
    output logic [lrupr_pkg::TOUT_W-1:0]     o_m_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lrupr_pkg::CAP_W-1:0]      i_cfg_data   // [4:0] capacity
);
    import lrupr_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    lrupr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lrupr_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_page_id   (i_s_tdata),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata)
    );

endmodule

### bench/tb.sv
// Self-checking testbench for the LRU page replacement unit: page reference streams against a recency-order predictor.
module tb;
    import lrupr_pkg::*;

    localparam int FRAMES      = MAX_FRAMES_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 8;

    typedef struct {
        logic [PAGE_ID_W-1:0] page;
        bit                   drain;
    } t_page_ref;

    // Declared from the top bit down so that it matches the result word bit for bit.
    typedef struct packed {
        logic [COUNT_W-1:0]   access_count;
        logic [COUNT_W-1:0]   hit_count;
        logic [PAGE_ID_W-1:0] evicted_page;
        logic                 evicted_valid;
        logic                 hit;
    } t_lru_verdict;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [PAGE_ID_W-1:0] i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [TOUT_W-1:0]    o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CAP_W-1:0]     i_cfg_data = '0;

    lru_page_replacement_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_page_ref     page_refs_q[$];
    t_lru_verdict  verdict_q[$];
    int            error_count = 0;
    bit            calm = 1'b0;
    bit            ref_taken = 1'b0;
    int            send_gap = 0;
    int            rx_stall = 0;
    int            burst_odds = 20;

    // Predictor state: pages held from least recent (index 0) to most recent.
    logic [PAGE_ID_W-1:0] frame_page[FRAMES] = '{default: '0};
    int                   frames_used = 0;
    logic [COUNT_W-1:0]   hits_seen = '0;
    logic [COUNT_W-1:0]   refs_seen = '0;
    logic [CAP_W-1:0]     capacity_reg = CAP_RESET;

    function automatic t_lru_verdict lru_lookup(input logic [PAGE_ID_W-1:0] page);
        t_lru_verdict v;
        int           limit;
        int           slot;
        v = '0;
        limit = (capacity_reg == 0) ? 1 : ((capacity_reg > FRAMES) ? FRAMES : capacity_reg);
        slot = -1;
        for (int i = 0; i < frames_used; i++) begin
            if (slot < 0 && frame_page[i] == page) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            for (int i = slot; i + 1 < frames_used; i++) begin
                frame_page[i] = frame_page[i+1];
            end
            frame_page[frames_used-1] = page;
            v.hit = 1'b1;
            if (hits_seen != '1) begin
                hits_seen = hits_seen + COUNT_W'(1);
            end
        end else if (frames_used < limit) begin
            frame_page[frames_used] = page;
            frames_used++;
        end else begin
            // A lowered capacity still evicts only one page, so occupancy stays put.
            v.evicted_valid = 1'b1;
            v.evicted_page = frame_page[0];
            for (int i = 0; i + 1 < frames_used; i++) begin
                frame_page[i] = frame_page[i+1];
            end
            frame_page[frames_used-1] = page;
        end
        if (refs_seen != '1) begin
            refs_seen = refs_seen + COUNT_W'(1);
        end
        v.hit_count = hits_seen;
        v.access_count = refs_seen;
        return v;
    endfunction

    function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                        input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Reference driver.
    always @(negedge i_clk) begin
        logic                 nv;
        logic [PAGE_ID_W-1:0] nd;
        t_page_ref            r;
        nv = i_s_tvalid;
        nd = i_s_tdata;
        if (!i_s_tvalid || ref_taken) begin
            nv = 1'b0;
            nd = PAGE_ID_W'($urandom);
            if (send_gap > 0) begin
                send_gap--;
            end else if (i_rst_n && page_refs_q.size() > 0 &&
                         !(page_refs_q[0].drain && verdict_q.size() != 0)) begin
                if (!calm && $urandom_range(0, burst_odds) == 0) begin
                    send_gap = $urandom_range(0, 9);
                end else begin
                    r = page_refs_q.pop_front();
                    nv = 1'b1;
                    nd = r.page;
                end
            end
        end
        i_s_tvalid <= nv;
        i_s_tdata <= nd;
    end

    // Result receiver with stall bursts.
    always @(negedge i_clk) begin
        if (calm) begin
            i_m_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, burst_odds) == 0) begin
            rx_stall = $urandom_range(0, 9);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted reference, then checks each accepted result.
    always @(posedge i_clk) begin
        t_lru_verdict got;
        t_lru_verdict want;
        if (!i_rst_n) begin
            ref_taken = 1'b0;
        end else begin
            ref_taken = i_s_tvalid && o_s_tready;
            if (i_cfg_valid && o_cfg_ready) begin
                capacity_reg = i_cfg_data;
            end
            if (ref_taken) begin
                verdict_q.push_back(lru_lookup(i_s_tdata));
            end
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[RES_W-1:0];
                if (verdict_q.size() == 0) begin
                    $error("result transaction with no reference outstanding: %h", o_m_tdata);
                    error_count++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("hit", COUNT_W'(want.hit), COUNT_W'(got.hit));
                    check_field("evicted_valid", COUNT_W'(want.evicted_valid),
                                COUNT_W'(got.evicted_valid));
                    check_field("evicted_page", COUNT_W'(want.evicted_page),
                                COUNT_W'(got.evicted_page));
                    check_field("hit_count", want.hit_count, got.hit_count);
                    check_field("access_count", want.access_count, got.access_count);
                end
            end
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic push_ref(input logic [PAGE_ID_W-1:0] page, input bit drain = 1'b0);
        t_page_ref r;
        r.page = page;
        r.drain = drain;
        page_refs_q.push_back(r);
    endtask

    // Waits until every reference has been answered, then lets the pipeline go quiet.
    task automatic settle();
        while (page_refs_q.size() != 0 || i_s_tvalid || verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data <= CAP_W'($urandom);
    endtask

    // Mostly references into a small working set so that hits and evictions are frequent.
    task automatic fill_random_refs(input int count, input int limit, input bit with_drain);
        logic [PAGE_ID_W-1:0] pool[24];
        logic [PAGE_ID_W-1:0] last;
        int                   pool_n;
        int                   pick;
        pool_n = $urandom_range(1, limit + 6);
        for (int i = 0; i < pool_n; i++) begin
            pool[i] = PAGE_ID_W'($urandom);
        end
        last = pool[0];
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                last = pool[$urandom_range(0, pool_n - 1)];
            end else if (pick >= 80) begin
                last = PAGE_ID_W'($urandom);
            end
            push_ref(last, (with_drain && i == count / 2) || $urandom_range(0, 199) == 0);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] caps[12];
        int               limit;
        caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd2, 5'd17, 5'd8, 5'd3, 5'd15, 5'd16, 5'd5};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset capacity: empty store, page zero against cleared frames, extreme page ids.
        push_ref(16'h0000);
        push_ref(16'hFFFF);
        push_ref(16'h0000);
        push_ref(16'hAAAA);
        push_ref(16'h5555);
        push_ref(16'hFFFF);
        push_ref(16'h0001);
        push_ref(16'h8000);
        settle();

        // Capacity zero acts as one, and is below the current occupancy.
        write_capacity(5'd0);
        push_ref(16'h1234);
        push_ref(16'h1234);
        push_ref(16'h4321);
        settle();

        // Capacity above the frame count saturates; grow to a full store, then evict.
        write_capacity(5'd31);
        for (int i = 0; i < 12; i++) begin
            push_ref(PAGE_ID_W'(16'h0100 + i));
        end
        settle();

        for (int p = 0; p < 12; p++) begin
            if (p >= 10) begin
                calm = 1'b1;
            end
            if (p >= 8) begin
                caps[p] = CAP_W'($urandom_range(0, 31));
            end
            burst_odds = (p % 3 == 2) ? 1000000 : $urandom_range(3, 25);
            write_capacity(caps[p]);
            limit = (caps[p] == 0) ? 1 : ((caps[p] > FRAMES) ? FRAMES : caps[p]);
            fill_random_refs(112, limit, p == 0);
            settle();
        end

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
design/lrupr_pkg.sv
design/lrupr_ctrl.sv
design/lrupr_dp.sv
design/lru_page_replacement_unit.sv
bench/tb.sv
